FILE: src/fct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants for the frustum cull test pipeline.
// ----------------------------------------------------------------------------
package fct_pkg;

   localparam int NUM_PLANES = 6;
   localparam int FRAC_BITS  = 14;
   localparam int COORD_W    = 17;   // corner coordinate, center +/- half-size
   localparam int COEF_W     = 16;   // plane coefficient, Q2.14 or integer
   localparam int PLANE_W    = 64;   // packed plane register
   localparam int IDX_W      = 3;    // register index
   localparam int BIAS_W     = 18;   // offset plus radius
   localparam int PROD_W     = COORD_W + COEF_W;
   localparam int SUM_W      = PROD_W + 3;

   // Operation codes of the input transaction
   typedef enum logic [1:0] {
      OP_CENTER_BOX = 2'd0,
      OP_MINMAX_BOX = 2'd1,
      OP_SPHERE     = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Work item that travels down the plane cells
   typedef struct packed {
      coord_type [2:0]           mn;      // per-axis lower corner choice
      coord_type [2:0]           mx;      // per-axis upper corner choice
      logic signed [BIAS_W-1:0]  bias;    // sphere radius, zero for a box
      logic                      test;    // volume is tested at all
      logic                      culled;  // culled by an earlier plane
   } item_type;

endpackage

FILE: src/fct_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_prep
// Input stage: forms per-axis min/max corner coordinates and the sphere bias.
// ----------------------------------------------------------------------------
module fct_prep
   import fct_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [1:0]               in_operation,
   input  logic signed [15:0]       in_first_x,
   input  logic signed [15:0]       in_first_y,
   input  logic signed [15:0]       in_first_z,
   input  logic signed [15:0]       in_second_x,
   input  logic signed [15:0]       in_second_y,
   input  logic signed [15:0]       in_second_z,
   input  logic [15:0]              in_sphere_radius,
   output logic                     out_valid,
   input  logic                     out_ready,
   output item_type                 out_item
);

   logic          valid_ff;
   item_type      item_ff;
   item_type      item_in;
   coord_type     f [3];
   coord_type     s [3];
   coord_type     lo [3];
   coord_type     hi [3];
   op_type        op;

   assign op       = op_type'(in_operation);
   assign in_ready = !valid_ff || out_ready;

   // Widen the coordinates exactly to corner width
   assign f[0] = COORD_W'(in_first_x);
   assign f[1] = COORD_W'(in_first_y);
   assign f[2] = COORD_W'(in_first_z);
   assign s[0] = COORD_W'(in_second_x);
   assign s[1] = COORD_W'(in_second_y);
   assign s[2] = COORD_W'(in_second_z);

   // Build the corner ranges for the operation
   always_comb begin
      item_in        = '0;
      item_in.culled = 1'b0;
      item_in.test   = 1'b1;
      item_in.bias   = '0;
      for (int i = 0; i < 3; i++) begin
         lo[i] = f[i];
         hi[i] = s[i];
      end
      case (op)
         OP_CENTER_BOX: begin
            for (int i = 0; i < 3; i++) begin
               lo[i] = f[i] - s[i];
               hi[i] = f[i] + s[i];
            end
         end
         OP_MINMAX_BOX: begin
            for (int i = 0; i < 3; i++) begin
               lo[i] = f[i];
               hi[i] = s[i];
            end
         end
         OP_SPHERE: begin
            for (int i = 0; i < 3; i++) begin
               lo[i] = f[i];
               hi[i] = f[i];
            end
            item_in.bias = BIAS_W'({2'b00, in_sphere_radius});
         end
         default: begin
            item_in.test = 1'b0;
         end
      endcase
      // Order each axis so the cells only pick by coefficient sign
      for (int i = 0; i < 3; i++) begin
         if (lo[i] <= hi[i]) begin
            item_in.mn[i] = lo[i];
            item_in.mx[i] = hi[i];
         end else begin
            item_in.mn[i] = hi[i];
            item_in.mx[i] = lo[i];
         end
      end
   end

   // Hold the stage until the first cell takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: src/fct_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_cell
// One plane cell: multiplies the farthest corner by the plane normal, then
// sums with the offset and marks the item culled on a negative distance.
// ----------------------------------------------------------------------------
module fct_cell
   import fct_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [PLANE_W-1:0]       plane,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  item_type                 in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output item_type                 out_item
);

   logic signed [COEF_W-1:0]  coef [3];
   logic signed [COEF_W-1:0]  offset;
   coord_type                 pick [3];
   logic signed [PROD_W-1:0]  prod_in [3];
   logic signed [PROD_W-1:0]  prod_ff [3];
   item_type                  mul_item_ff;
   logic                      mul_valid_ff;
   logic                      mul_ready;
   logic signed [BIAS_W-1:0]  bias_sum;
   logic signed [SUM_W-1:0]   distance;
   item_type                  sum_item_in;
   item_type                  sum_item_ff;
   logic                      sum_valid_ff;
   logic                      sum_ready;

   // Unpack the plane register
   assign coef[0] = plane[15:0];
   assign coef[1] = plane[31:16];
   assign coef[2] = plane[47:32];
   assign offset  = plane[63:48];

   // Pick the corner that maximizes the distance, one product per axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pick[i]    = coef[i][COEF_W-1] ? $signed(in_item.mn[i]) : $signed(in_item.mx[i]);
         prod_in[i] = PROD_W'(pick[i]) * PROD_W'(coef[i]);
      end
   end

   assign sum_ready = !sum_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || sum_ready;
   assign in_ready  = mul_ready;

   // Multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         mul_item_ff <= in_item;
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   // Sum stage: distance plus radius below zero means outside this plane
   assign bias_sum = BIAS_W'(offset) + mul_item_ff.bias;

   always_comb begin
      distance = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2])
               + SUM_W'($signed({bias_sum, {FRAC_BITS{1'b0}}}));
      sum_item_in        = mul_item_ff;
      sum_item_in.culled = mul_item_ff.culled
                         | (mul_item_ff.test & distance[SUM_W-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (sum_ready) begin
         sum_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && mul_valid_ff) begin
         sum_item_ff <= sum_item_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_item  = sum_item_ff;

endmodule

FILE: src/frustum_cull_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_test
// Tests a box or sphere against six frustum planes held in registers.
//
//   channel   ports                 direction   handshake
//   request   req_*                 in          req_valid / req_ready
//   response  rsp_visible           out         rsp_valid / rsp_ready
//   csr       csr_we/index/wdata    in          write on csr_we, no wait
//
// Throughput is one transaction per cycle while rsp_ready stays high. There is
// one prep stage, then six plane cells of two stages each (multiply, sum).
// Every stage has its own valid and a ready chain, so empty stages fill
// while the response waits. Synchronous reset empties the pipeline and
// clears all plane registers, which makes every volume visible.
// ----------------------------------------------------------------------------
module frustum_cull_test
   import fct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic signed [15:0]    req_first_x,
   input  logic signed [15:0]    req_first_y,
   input  logic signed [15:0]    req_first_z,
   input  logic signed [15:0]    req_second_x,
   input  logic signed [15:0]    req_second_y,
   input  logic signed [15:0]    req_second_z,
   input  logic [15:0]           req_sphere_radius,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_visible,
   input  logic                  csr_we,
   input  logic [IDX_W-1:0]      csr_index,
   input  logic [PLANE_W-1:0]    csr_wdata
);

   logic [PLANE_W-1:0]  plane_ff [NUM_PLANES];
   logic                chain_valid [NUM_PLANES+1];
   logic                chain_ready [NUM_PLANES+1];
   item_type            chain_item  [NUM_PLANES+1];

   // Plane registers; writes beyond the last plane are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_we && (csr_index < IDX_W'(NUM_PLANES))) begin
         plane_ff[csr_index] <= csr_wdata;
      end
   end

   // Corner preparation
   fct_prep u_prep (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_ready         (req_ready),
      .in_operation     (req_operation),
      .in_first_x       (req_first_x),
      .in_first_y       (req_first_y),
      .in_first_z       (req_first_z),
      .in_second_x      (req_second_x),
      .in_second_y      (req_second_y),
      .in_second_z      (req_second_z),
      .in_sphere_radius (req_sphere_radius),
      .out_valid        (chain_valid[0]),
      .out_ready        (chain_ready[0]),
      .out_item         (chain_item[0])
   );

   // Row of plane cells, each passing the transaction to its neighbor
   for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
      fct_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .plane     (plane_ff[g]),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_item   (chain_item[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_item  (chain_item[g+1])
      );
   end

   // Response from the last cell
   assign rsp_valid                = chain_valid[NUM_PLANES];
   assign chain_ready[NUM_PLANES]  = rsp_ready;
   assign rsp_visible              = !chain_item[NUM_PLANES].culled;

endmodule
